/* rtl/tfn_pkg.sv */
// package: widths, constants and the restoring unit-vector step for the face normal block
package tfn_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int VW    = 32;          // width of every item field
    localparam int NV    = 9;           // coordinates in one input item
    localparam int NOUT  = 6;           // fields in one result item
    localparam int EDW   = 33;          // edge component
    localparam int PRW   = 66;          // edge product
    localparam int CRW   = 67;          // cross product component, signed
    localparam int MGW   = 65;          // cross product magnitude
    localparam int SQW   = 130;         // squared component
    localparam int SW    = 132;         // squared length
    localparam int EW    = 192;         // remainder of the unit step
    localparam int PW    = 164;         // running s * q
    localparam int RW    = 198;         // trial difference, signed
    localparam int QW    = 31;          // unit magnitude bits
    localparam int NSTEP = 31;          // one stage per unit bit
    localparam int TW    = 35;          // biased centroid sum
    localparam int CPW   = TW + 18;     // centroid partial product
    localparam int CSW   = TW + 36;     // centroid full product
    localparam int CSHIFT = 37;
    localparam logic [35:0] CDIV = 36'd45812984491;   // ceil(2^37 / 3)
    localparam int UNIT_FRAC = 30;
    localparam int REGW  = 1;

    typedef enum logic [REGW-1:0] {
        REG_NORMAL_LENGTH = 1'b0,
        REG_MIN_MAGNITUDE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [EW-1:0] e;
        logic [PW-1:0] p;
        logic [QW-1:0] q;
    } t_lane;

    typedef struct packed {
        logic                 vld;
        logic                 zero;
        logic [SW-1:0]        s;
        logic [2:0]           neg;
        logic [2:0][VW-1:0]   center;
        t_lane [2:0]          lane;
    } t_sq_stage;

    // try one more unit bit: keep it when q^2 * s still fits under c^2 << 60
    function automatic t_lane sq_step(t_lane x, logic [SW-1:0] s, int b);
        t_lane         r;
        logic [RW-1:0] d;
        r = x;
        d = RW'(x.e) - (RW'(x.p) << (b + 1)) - (RW'(s) << (2 * b));
        if (!d[RW-1]) begin
            r.e = d[EW-1:0];
            r.p = x.p + (PW'(s) << b);
            r.q = x.q | (QW'(1) << b);
        end
        return r;
    endfunction

endpackage

/* rtl/triangle_face_normal_segment_top.sv */
// top level: triangle centroid and face normal segment, fully pipelined
//
// one triangle (nine signed Q16.16 coordinates) enters per clock unless the pipeline halts,
// and at most one result leaves per clock. the result carries the centroid (rounded to
// nearest) and the tip of the normal segment, centroid plus unit normal times
// normal_length, saturated to 32 bits. triangles whose cross product magnitude, truncated
// to Q16.16, lies below min_magnitude are dropped and give no result. each item passes
// through seven stages of edge, product and squared-length arithmetic, then one stage per
// bit of the Q1.30 unit vector (31 restoring compare-and-subtract stages on the exact
// squared length, which set the depth), one multiply stage for the segment offset and the
// output register. a two-entry output register with skid keeps input ready registered;
// the pipeline halts as a whole only while the skid entry is full. configuration writes
// are taken at any time but must only happen while the block is idle. no clearing pass.
module triangle_face_normal_segment_top #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [tfn_pkg::REGW-1:0]      i_cfg_addr,
    input  logic [tfn_pkg::VW-1:0]        i_cfg_data,
    // input items
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz, 32 bits each from bit 0 up
    input  logic [tfn_pkg::NV*tfn_pkg::VW-1:0]   i_s_tdata,
    // result items
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // center_x, center_y, center_z, tip_x, tip_y, tip_z, 32 bits each from bit 0 up
    output logic [tfn_pkg::NOUT*tfn_pkg::VW-1:0] o_m_tdata
);

    localparam int VW = tfn_pkg::VW;
    localparam int NS = tfn_pkg::NSTEP;

    // configuration registers
    logic signed [VW-1:0]   r_norm_len;
    logic [VW-1:0]          r_min_mag;
    logic [2*VW-1:0]        r_min_sq;

    // pipeline control
    logic en;
    logic take;

    // input unpacking with sign extension of the low coordinate bits
    logic signed [COORD_WIDTH-1:0] w_in [tfn_pkg::NV];
    logic signed [VW-1:0]          w_v  [tfn_pkg::NV];

    // stage 1: edges and biased centroid sum
    logic                          r1_vld;
    logic signed [tfn_pkg::EDW-1:0] r1_e1 [3];
    logic signed [tfn_pkg::EDW-1:0] r1_e2 [3];
    logic [tfn_pkg::TW-1:0]        r1_t  [3];
    // stage 2: edge products and centroid partial products
    logic                          r2_vld;
    logic signed [tfn_pkg::PRW-1:0] r2_pa [3];
    logic signed [tfn_pkg::PRW-1:0] r2_pb [3];
    logic [tfn_pkg::CPW-1:0]       r2_c0 [3];
    logic [tfn_pkg::CPW-1:0]       r2_c1 [3];
    // stage 3: cross product and centroid
    logic                          r3_vld;
    logic signed [tfn_pkg::CRW-1:0] r3_c [3];
    logic [VW-1:0]                 r3_ctr [3];
    // stage 4: magnitude and sign
    logic                          r4_vld;
    logic [tfn_pkg::MGW-1:0]       r4_mag [3];
    logic [2:0]                    r4_neg;
    logic [VW-1:0]                 r4_ctr [3];
    // stage 5: partial squares
    logic                          r5_vld;
    logic [65:0]                   r5_hh [3];
    logic [64:0]                   r5_hl [3];
    logic [63:0]                   r5_ll [3];
    logic [2:0]                    r5_neg;
    logic [VW-1:0]                 r5_ctr [3];
    // stage 6: squared components
    logic                          r6_vld;
    logic [tfn_pkg::SQW-1:0]       r6_csq [3];
    logic [2:0]                    r6_neg;
    logic [VW-1:0]                 r6_ctr [3];
    // stage 7: squared length
    logic                          r7_vld;
    logic [tfn_pkg::SW-1:0]        r7_s;
    logic [tfn_pkg::SQW-1:0]       r7_csq [3];
    logic [2:0]                    r7_neg;
    logic [VW-1:0]                 r7_ctr [3];
    // unit vector stages
    tfn_pkg::t_sq_stage            r_sq [NS];
    tfn_pkg::t_sq_stage            n_sq [NS];
    logic                          w_degen;
    // offset multiply stage
    logic                          rt_vld;
    logic signed [2*VW-1:0]        rt_prod [3];
    logic [VW-1:0]                 rt_ctr [3];
    logic signed [VW-1:0]          w_unit [3];
    // output register and skid entry
    logic                          r_out_vld;
    logic [tfn_pkg::NOUT*VW-1:0]   r_out;
    logic                          r_skid_vld;
    logic [tfn_pkg::NOUT*VW-1:0]   r_skid;
    logic [tfn_pkg::NOUT*VW-1:0]   w_res;

    assign en         = !r_skid_vld;
    assign o_s_tready = en;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;
    assign take       = r_out_vld && i_m_tready;

    always_comb begin
        for (int i = 0; i < tfn_pkg::NV; i++) begin
            w_in[i] = i_s_tdata[VW*i +: COORD_WIDTH];
            w_v[i]  = VW'(w_in[i]);
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_len <= 32'sd65536;
            r_min_mag  <= 32'd1;
            r_min_sq   <= 64'd1;
        end else begin
            r_min_sq <= r_min_mag * r_min_mag;
            if (i_cfg_we) begin
                unique case (tfn_pkg::t_reg_idx'(i_cfg_addr))
                    tfn_pkg::REG_NORMAL_LENGTH: r_norm_len <= i_cfg_data;
                    tfn_pkg::REG_MIN_MAGNITUDE: r_min_mag  <= i_cfg_data;
                endcase
            end
        end
    end

    // front stages: edges, products, cross product, squared length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_s_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [35:0]         sum3;
        logic [tfn_pkg::CSW-1:0] csum;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                // stage 1
                r1_e1[i] <= tfn_pkg::EDW'(w_v[3+i]) - tfn_pkg::EDW'(w_v[i]);
                r1_e2[i] <= tfn_pkg::EDW'(w_v[6+i]) - tfn_pkg::EDW'(w_v[i]);
                // bias keeps the sum positive so floor division by three rounds right
                sum3 = 36'(w_v[i]) + 36'(w_v[3+i]) + 36'(w_v[6+i]) + 36'sd1
                       + 36'sd25769803776;
                r1_t[i] <= sum3[tfn_pkg::TW-1:0];
                // stage 2: divide by three through the reciprocal in two halves
                r2_c0[i] <= r1_t[i] * tfn_pkg::CDIV[17:0];
                r2_c1[i] <= r1_t[i] * tfn_pkg::CDIV[35:18];
                // stage 3
                r3_c[i] <= tfn_pkg::CRW'(r2_pa[i]) - tfn_pkg::CRW'(r2_pb[i]);
                csum = tfn_pkg::CSW'(r2_c0[i]) + (tfn_pkg::CSW'(r2_c1[i]) << 18);
                r3_ctr[i] <= csum[tfn_pkg::CSHIFT +: VW];
                // stage 4
                r4_neg[i] <= r3_c[i][tfn_pkg::CRW-1];
                r4_mag[i] <= r3_c[i][tfn_pkg::CRW-1] ? tfn_pkg::MGW'(-r3_c[i])
                                                     : tfn_pkg::MGW'(r3_c[i]);
                r4_ctr[i] <= r3_ctr[i];
                // stage 5: square split into 33 and 32 bit halves
                r5_hh[i]  <= r4_mag[i][64:32] * r4_mag[i][64:32];
                r5_hl[i]  <= r4_mag[i][64:32] * r4_mag[i][31:0];
                r5_ll[i]  <= r4_mag[i][31:0] * r4_mag[i][31:0];
                r5_neg[i] <= r4_neg[i];
                r5_ctr[i] <= r4_ctr[i];
                // stage 6
                r6_csq[i] <= (tfn_pkg::SQW'(r5_hh[i]) << 64) + (tfn_pkg::SQW'(r5_hl[i]) << 33)
                             + tfn_pkg::SQW'(r5_ll[i]);
                r6_neg[i] <= r5_neg[i];
                r6_ctr[i] <= r5_ctr[i];
                // stage 7
                r7_csq[i] <= r6_csq[i];
                r7_neg[i] <= r6_neg[i];
                r7_ctr[i] <= r6_ctr[i];
            end
            // cross product terms of a->b and a->c
            r2_pa[0] <= r1_e1[1] * r1_e2[2];
            r2_pb[0] <= r1_e1[2] * r1_e2[1];
            r2_pa[1] <= r1_e1[2] * r1_e2[0];
            r2_pb[1] <= r1_e1[0] * r1_e2[2];
            r2_pa[2] <= r1_e1[0] * r1_e2[1];
            r2_pb[2] <= r1_e1[1] * r1_e2[0];
            r7_s <= tfn_pkg::SW'(r6_csq[0]) + tfn_pkg::SW'(r6_csq[1]) + tfn_pkg::SW'(r6_csq[2]);
        end
    end

    // degenerate when floor(|c|) in Q16.16 is below the threshold, tested on squares
    assign w_degen = r7_s[tfn_pkg::SW-1:32] < (tfn_pkg::SW-32)'(r_min_sq);

    // unit vector stages, one bit of each component per stage
    always_comb begin
        tfn_pkg::t_sq_stage init;
        init.vld  = r7_vld && !w_degen;
        init.zero = (r7_s == '0);
        init.s    = r7_s;
        for (int i = 0; i < 3; i++) begin
            init.neg[i]    = r7_neg[i];
            init.center[i] = r7_ctr[i];
            init.lane[i].e = tfn_pkg::EW'(r7_csq[i]) << (2 * tfn_pkg::UNIT_FRAC);
            init.lane[i].p = '0;
            init.lane[i].q = '0;
        end
        for (int k = 0; k < NS; k++) begin
            n_sq[k] = (k == 0) ? init : r_sq[(k == 0) ? 0 : k - 1];
            for (int i = 0; i < 3; i++) begin
                n_sq[k].lane[i] = tfn_pkg::sq_step(n_sq[k].lane[i], n_sq[k].s, NS - 1 - k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_sq[k].vld <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < NS; k++) begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    // segment offset: signed unit times normal_length
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_sq[NS-1].zero) begin
                w_unit[i] = '0;
            end else if (r_sq[NS-1].neg[i]) begin
                w_unit[i] = -VW'(r_sq[NS-1].lane[i].q);
            end else begin
                w_unit[i] = VW'(r_sq[NS-1].lane[i].q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rt_vld <= 1'b0;
        end else if (en) begin
            rt_vld <= r_sq[NS-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rt_prod[i] <= w_unit[i] * r_norm_len;
                rt_ctr[i]  <= r_sq[NS-1].center[i];
            end
        end
    end

    // round offset to nearest (ties up), add centroid, saturate
    always_comb begin
        logic signed [2*VW-1:0] p;
        logic signed [2*VW-1:0] d;
        logic signed [VW+1:0]   r;
        w_res = '0;
        for (int i = 0; i < 3; i++) begin
            p = rt_prod[i] + (64'sd1 <<< (tfn_pkg::UNIT_FRAC - 1));
            d = p >>> tfn_pkg::UNIT_FRAC;
            r = (VW+2)'($signed(rt_ctr[i])) + d[VW+1:0];
            w_res[VW*i +: VW] = rt_ctr[i];
            if (r > (VW+2)'(34'sh07FFFFFFF)) begin
                w_res[VW*(3+i) +: VW] = 32'h7FFFFFFF;
            end else if (r < -(VW+2)'(34'sh080000000)) begin
                w_res[VW*(3+i) +: VW] = 32'h80000000;
            end else begin
                w_res[VW*(3+i) +: VW] = r[VW-1:0];
            end
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (rt_vld) begin
            if (!r_out_vld || take) begin
                r_out     <= w_res;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= w_res;
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    // a held skid item always has an output item in front of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry full with output register empty");

    // a taken output has drained the skid entry by the next cycle
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_m_tready) |=> (!r_skid_vld && r_out_vld))
        else $error("skid entry not drained after output accept");

    // an accepted item always enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r1_vld)
        else $error("accepted item lost at pipeline entry");

endmodule

/* tb/tb_triangle_face_normal_segment_top.sv */
// testbench for the triangle face normal segment block
`timescale 1ns / 100ps

module tb_triangle_face_normal_segment_top;

    localparam int LATENCY = 40;
    // cycles without any accepted item before the run is abandoned
    localparam int STALL_LIMIT = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tfn_pkg::REGW-1:0] i_cfg_addr = '0;
    logic [tfn_pkg::VW-1:0] i_cfg_data = '0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz from the lowest bit up
    logic [tfn_pkg::NV*tfn_pkg::VW-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    // center_x, center_y, center_z, tip_x, tip_y, tip_z from the lowest bit up
    logic [tfn_pkg::NOUT*tfn_pkg::VW-1:0] o_m_tdata;

    triangle_face_normal_segment_top dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow copies of the configuration registers
    longint seg_length = 65536;
    logic [31:0] degen_floor = 32'd1;

    logic [tfn_pkg::NOUT*tfn_pkg::VW-1:0] pending_normals[$];
    int errors = 0;
    bit calm = 1'b0;      // no idling on either side
    bit hold_req = 1'b0;  // receiver long hold-off request
    int idle_cnt = 0;

    function automatic logic signed [255:0] wide_mul(longint x, longint y);
        logic signed [255:0] a, b;
        a = x;
        b = y;
        return a * b;
    endfunction

    function automatic longint centroid_of(longint a, longint b, longint c);
        longint bias;
        bias = longint'(1) <<< 33;
        return (a + b + c + 1 + 3 * bias) / 3 - bias;
    endfunction

    // computes the result item for one triangle; keep is cleared for a degenerate one
    function automatic logic [tfn_pkg::NOUT*tfn_pkg::VW-1:0] face_normal(
            logic [tfn_pkg::NV*tfn_pkg::VW-1:0] tri_bits, output bit keep);
        longint v[9], e1[3], e2[3], ctr, unit, prod, off, tip;
        logic signed [255:0] cr[3];
        logic [255:0] cm[3], s, thr, rhs, t;
        bit neg[3];
        logic [31:0] q;
        logic [tfn_pkg::NOUT*tfn_pkg::VW-1:0] r;
        for (int i = 0; i < 9; i++)
            v[i] = longint'(signed'(tri_bits[i*tfn_pkg::VW +: tfn_pkg::VW]));
        for (int i = 0; i < 3; i++) begin
            e1[i] = v[3+i] - v[i];
            e2[i] = v[6+i] - v[i];
        end
        cr[0] = wide_mul(e1[1], e2[2]) - wide_mul(e1[2], e2[1]);
        cr[1] = wide_mul(e1[2], e2[0]) - wide_mul(e1[0], e2[2]);
        cr[2] = wide_mul(e1[0], e2[1]) - wide_mul(e1[1], e2[0]);
        for (int i = 0; i < 3; i++) begin
            neg[i] = cr[i] < 0;
            cm[i] = neg[i] ? -cr[i] : cr[i];
        end
        s = cm[0] * cm[0] + cm[1] * cm[1] + cm[2] * cm[2];
        thr = degen_floor;
        thr = thr * thr;
        keep = (s >> 32) >= thr;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            q = '0;
            if (s != 0) begin
                rhs = (cm[i] * cm[i]) << 60;
                for (int b = 30; b >= 0; b--) begin
                    t = q | (32'd1 << b);
                    if (t * t * s <= rhs) q = t[31:0];
                end
            end
            unit = neg[i] ? -longint'(q) : longint'(q);
            ctr = centroid_of(v[i], v[3+i], v[6+i]);
            prod = unit * seg_length + (longint'(1) <<< 29);
            off = prod >>> tfn_pkg::UNIT_FRAC;
            tip = ctr + off;
            if (tip > 64'sd2147483647) tip = 64'sd2147483647;
            if (tip < -64'sd2147483648) tip = -64'sd2147483648;
            r[i*tfn_pkg::VW +: tfn_pkg::VW] = ctr[31:0];
            r[(3+i)*tfn_pkg::VW +: tfn_pkg::VW] = tip[31:0];
        end
        return r;
    endfunction

    function automatic string field_name(int i);
        case (i)
            0: return "center_x";
            1: return "center_y";
            2: return "center_z";
            3: return "tip_x";
            4: return "tip_y";
            default: return "tip_z";
        endcase
    endfunction

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        logic [tfn_pkg::NOUT*tfn_pkg::VW-1:0] exp_item;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_normals.size() == 0) begin
                $error("unexpected result item %h", o_m_tdata);
                errors++;
            end else begin
                exp_item = pending_normals.pop_front();
                for (int i = 0; i < tfn_pkg::NOUT; i++)
                    if (o_m_tdata[i*tfn_pkg::VW +: tfn_pkg::VW] !==
                        exp_item[i*tfn_pkg::VW +: tfn_pkg::VW]) begin
                        $error("%s: expected %h, got %h", field_name(i),
                               exp_item[i*tfn_pkg::VW +: tfn_pkg::VW],
                               o_m_tdata[i*tfn_pkg::VW +: tfn_pkg::VW]);
                        errors++;
                    end
            end
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cnt <= 0;
        end else if (i_rst_n) begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt > STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // result receiver: random stall bursts, or a long counted hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // sends one triangle, leaving tvalid high after acceptance
    task automatic send_triangle(logic [tfn_pkg::NV*tfn_pkg::VW-1:0] tri_bits);
        bit keep;
        logic [tfn_pkg::NOUT*tfn_pkg::VW-1:0] res;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_s_tdata = tri_bits;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        res = face_normal(tri_bits, keep);
        if (keep) pending_normals = {pending_normals, res};
    endtask

    function automatic logic [tfn_pkg::NV*tfn_pkg::VW-1:0] make_tri(
            logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        return {cz, cy, cx, bz, by, bx, az, ay, ax};
    endfunction

    // sender pauses until every outstanding result is out, then covers in-flight drops
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_normals.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(tfn_pkg::t_reg_idx idx, logic [31:0] val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == tfn_pkg::REG_NORMAL_LENGTH) seg_length = longint'(signed'(val));
        else degen_floor = val;
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 2 ** 21) - 2 ** 20;
            2: return $urandom_range(0, 2) == 0 ? 32'h7fffffff :
                      ($urandom_range(0, 1) ? 32'h80000000 : 32'h00000000);
            default: return $urandom_range(0, 16) - 8;
        endcase
    endfunction

    task automatic send_random(int n);
        logic [tfn_pkg::NV*tfn_pkg::VW-1:0] t;
        int mode;
        longint k;
        for (int j = 0; j < n; j++) begin
            mode = $urandom_range(0, 9);
            for (int i = 0; i < tfn_pkg::NV; i++)
                t[i*tfn_pkg::VW +: tfn_pkg::VW] =
                    rand_coord(mode < 4 ? 0 : mode < 7 ? 1 : mode < 8 ? 2 : 3);
            // now and then make the third vertex nearly collinear with the first two
            if ($urandom_range(0, 5) == 0) begin
                k = longint'($urandom_range(0, 4)) - 2;
                for (int i = 0; i < 3; i++)
                    t[(6+i)*tfn_pkg::VW +: tfn_pkg::VW] = t[i*tfn_pkg::VW +: tfn_pkg::VW]
                        + k * (t[(3+i)*tfn_pkg::VW +: tfn_pkg::VW]
                        - t[i*tfn_pkg::VW +: tfn_pkg::VW]) + $urandom_range(0, 2) - 1;
            end
            send_triangle(t);
        end
    endtask

    task automatic test_directed();
        write_reg(tfn_pkg::REG_NORMAL_LENGTH, 32'd65536);
        write_reg(tfn_pkg::REG_MIN_MAGNITUDE, 32'd1);
        // all-zero triangle is degenerate
        send_triangle('0);
        // unit right triangle in the xy plane
        send_triangle(make_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
        send_triangle(make_tri(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0));
        // tiny triangle whose magnitude truncates to zero
        send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        // coordinate extremes
        send_triangle({tfn_pkg::NV{32'h7fffffff}});
        send_triangle({tfn_pkg::NV{32'h80000000}});
        send_triangle({tfn_pkg::NV{32'hffffffff}});
        send_triangle(make_tri(32'h80000000, 32'h80000000, 32'h80000000,
                               32'h7fffffff, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h7fffffff, 32'h7fffffff));
        send_triangle(make_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h80000000, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 32'h80000000, 32'h7fffffff));
        // collinear points
        send_triangle(make_tri(0, 0, 0, 32'h10000, 32'h20000, 32'h30000,
                               32'h20000, 32'h40000, 32'h60000));
        // zero threshold: zero cross product still gives a result, tip at centroid
        write_reg(tfn_pkg::REG_MIN_MAGNITUDE, 32'd0);
        send_triangle('0);
        send_triangle(make_tri(5, 7, 9, 5, 7, 9, 5, 7, 9));
        send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        // segment length extremes with saturation
        write_reg(tfn_pkg::REG_NORMAL_LENGTH, 32'h7fffffff);
        send_triangle(make_tri(32'h7fff0000, 0, 0, 32'h7fff0000, 32'h10000, 0,
                               32'h7fff0000, 0, 32'h10000));
        send_triangle(make_tri(0, 0, 32'h7fffffff, 32'h10000, 0, 32'h7fffffff,
                               0, 32'h10000, 32'h7fffffff));
        write_reg(tfn_pkg::REG_NORMAL_LENGTH, 32'h80000000);
        send_triangle(make_tri(32'h7fff0000, 0, 0, 32'h7fff0000, 32'h10000, 0,
                               32'h7fff0000, 0, 32'h10000));
        send_triangle(make_tri(0, 0, 32'h80000000, 32'h10000, 0, 32'h80000000,
                               0, 32'h10000, 32'h80000000));
        // largest threshold
        write_reg(tfn_pkg::REG_MIN_MAGNITUDE, 32'hffffffff);
        send_triangle(make_tri(32'h80000000, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 0,
                               32'h80000000, 32'h7fffffff, 0));
        send_triangle(make_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
    endtask

    task automatic test_settings();
        write_reg(tfn_pkg::REG_NORMAL_LENGTH, 32'd65536);
        write_reg(tfn_pkg::REG_MIN_MAGNITUDE, 32'd1);
        send_random(200);
        write_reg(tfn_pkg::REG_NORMAL_LENGTH, 32'h80000000);
        write_reg(tfn_pkg::REG_MIN_MAGNITUDE, 32'd0);
        send_random(120);
        write_reg(tfn_pkg::REG_NORMAL_LENGTH, 32'h7fffffff);
        write_reg(tfn_pkg::REG_MIN_MAGNITUDE, $urandom_range(1, 1 << 20));
        send_random(120);
        write_reg(tfn_pkg::REG_NORMAL_LENGTH, $urandom);
        write_reg(tfn_pkg::REG_MIN_MAGNITUDE, 32'hffffffff);
        send_random(60);
    endtask

    task automatic test_backpressure();
        write_reg(tfn_pkg::REG_NORMAL_LENGTH, 32'h00030000);
        write_reg(tfn_pkg::REG_MIN_MAGNITUDE, 32'd0);
        // receiver holds off while items keep coming, filling the pipeline
        hold_req = 1'b1;
        send_random(100);
        wait_drained();
    endtask

    task automatic test_streaming();
        write_reg(tfn_pkg::REG_NORMAL_LENGTH, $urandom);
        write_reg(tfn_pkg::REG_MIN_MAGNITUDE, $urandom_range(0, 255));
        // closing stretch at full rate with no idling
        calm = 1'b1;
        send_random(150);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_settings();
        test_backpressure();
        test_streaming();
        wait_drained();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
